// ===== hdl/lrtd_pkg.sv =====
package lrtd_pkg;

    // lane marker bytes
    localparam logic [7:0] LANE_FS = 8'h1c;
    localparam logic [7:0] LANE_GS = 8'h1d;
    localparam logic [7:0] LANE_RS = 8'h1e;
    localparam logic [7:0] LANE_US = 8'h1f;

    // header length in bytes, and the positions of the two reported bytes
    localparam int unsigned HEADER_BYTES = 8;
    localparam logic [2:0] HDR_INPUT_IDX = 3'(HEADER_BYTES - 2);
    localparam logic [2:0] HDR_STATE_IDX = 3'(HEADER_BYTES - 1);

    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 40;

    typedef enum logic [2:0] {
        ITEM_HDR_INPUT = 3'd0,
        ITEM_HDR_STATE = 3'd1,
        ITEM_REC_OPEN  = 3'd2,
        ITEM_PAYLOAD   = 3'd3,
        ITEM_END       = 3'd4
    } item_type_t;

    typedef enum logic [2:0] {
        CLS_FS      = 3'd0,
        CLS_GS      = 3'd1,
        CLS_RS      = 3'd2,
        CLS_US      = 3'd3,
        CLS_UNKNOWN = 3'd4
    } lane_class_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_HEADER  = 2'd1,
        ST_TRUNCATED  = 2'd2,
        ST_LEN_EXCEED = 2'd3
    } status_t;

    function automatic lane_class_t classify(input logic [7:0] lane);
        lane_class_t cls;
        case (lane)
            LANE_FS: cls = CLS_FS;
            LANE_GS: cls = CLS_GS;
            LANE_RS: cls = CLS_RS;
            LANE_US: cls = CLS_US;
            default: cls = CLS_UNKNOWN;
        endcase
        return cls;
    endfunction

endpackage

// ===== hdl/lane_record_tape_deframer.sv =====
// lane record tape deframer
//
// slave channel: one transfer per tape item; s_tdata carries the tape byte and
// s_tuser flags end of tape (the byte is then ignored). header bytes 0 to 5 are
// dropped, bytes 6 and 7 are passed on, then each record (lane byte, 16-bit
// big-endian length, payload) gives one record-open transfer and one transfer
// per payload byte, m_tlast marking the last byte or an empty record's open.
// end of tape gives one status transfer and re-arms for the next tape.
// payload is streamed before truncation is known: on a non-ok status the
// consumer throws away the final record.
//
// each result is registered and is presented in the cycle after its input transfer.
// throughput: one input transfer per cycle; a single output register holds the
// result, and s_tready stays high while that register is empty or being drained
// in the same cycle, so a stalled receiver holds back the input only.
// reset (aresetn low, synchronous) returns the parser to the header phase and
// empties the output register.
module lane_record_tape_deframer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lrtd_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] tape_byte
    input  logic                            s_tuser,   // [0] kind (end of tape)
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] lane_code, [10:8] lane_class, [18:11] byte_value,
    // [34:19] record_length, [36:35] status, [39:37] zero
    output logic [lrtd_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [2:0]                      m_tuser,   // [2:0] item_type
    output logic                            m_tlast
);
    import lrtd_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_LANE    = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [2:0]  header_count_reg, header_count_next;
    logic [7:0]  current_lane_reg, current_lane_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic [15:0] declared_length_reg, declared_length_next;
    logic [15:0] remaining_reg, remaining_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    item_type_t  item_type_reg, item_type_next;
    logic [7:0]  lane_code_reg, lane_code_next;
    lane_class_t lane_class_reg, lane_class_next;
    logic [7:0]  byte_value_reg, byte_value_next;
    logic [15:0] record_length_reg, record_length_next;
    logic        last_reg, last_next;
    status_t     status_reg, status_next;

    logic        s_fire;
    logic        emit;
    logic [7:0]  tape_byte;
    logic [15:0] full_length;
    logic [15:0] remaining_dec;

    // output register either empty or drained this cycle
    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    assign tape_byte     = s_tdata[7:0];
    assign full_length   = {length_high_reg, tape_byte};
    assign remaining_dec = remaining_reg - 16'd1;

    always_comb begin
        phase_next           = phase_reg;
        header_count_next    = header_count_reg;
        current_lane_next    = current_lane_reg;
        length_high_next     = length_high_reg;
        declared_length_next = declared_length_reg;
        remaining_next       = remaining_reg;

        emit               = 1'b0;
        item_type_next     = item_type_reg;
        lane_code_next     = lane_code_reg;
        lane_class_next    = lane_class_reg;
        byte_value_next    = byte_value_reg;
        record_length_next = record_length_reg;
        last_next          = last_reg;
        status_next        = status_reg;

        if (s_fire) begin
            if (s_tuser) begin
                // end of tape: report where the tape stopped, then re-arm
                emit               = 1'b1;
                item_type_next     = ITEM_END;
                lane_code_next     = 8'd0;
                lane_class_next    = CLS_FS;
                byte_value_next    = 8'd0;
                record_length_next = 16'd0;
                last_next          = 1'b0;
                case (phase_reg)
                    PH_LANE:              status_next = ST_OK;
                    PH_LEN_HI, PH_LEN_LO: status_next = ST_TRUNCATED;
                    PH_PAYLOAD:           status_next = ST_LEN_EXCEED;
                    default:              status_next = ST_NO_HEADER;
                endcase
                phase_next           = PH_HEADER;
                header_count_next    = 3'd0;
                current_lane_next    = 8'd0;
                length_high_next     = 8'd0;
                declared_length_next = 16'd0;
                remaining_next       = 16'd0;
            end else begin
                case (phase_reg)
                    PH_LANE: begin
                        current_lane_next = tape_byte;
                        phase_next        = PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        length_high_next = tape_byte;
                        phase_next       = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        declared_length_next = full_length;
                        remaining_next       = full_length;
                        phase_next = (full_length == 16'd0) ? PH_LANE : PH_PAYLOAD;
                        emit               = 1'b1;
                        item_type_next     = ITEM_REC_OPEN;
                        lane_code_next     = current_lane_reg;
                        lane_class_next    = classify(current_lane_reg);
                        byte_value_next    = 8'd0;
                        record_length_next = full_length;
                        last_next          = (full_length == 16'd0);
                        status_next        = ST_OK;
                    end
                    PH_PAYLOAD: begin
                        remaining_next = remaining_dec;
                        if (remaining_dec == 16'd0) begin
                            phase_next = PH_LANE;
                        end
                        emit               = 1'b1;
                        item_type_next     = ITEM_PAYLOAD;
                        lane_code_next     = current_lane_reg;
                        lane_class_next    = classify(current_lane_reg);
                        byte_value_next    = tape_byte;
                        record_length_next = declared_length_reg;
                        last_next          = (remaining_dec == 16'd0);
                        status_next        = ST_OK;
                    end
                    default: begin
                        // header phase; stray codes are handled the same way
                        phase_next         = PH_HEADER;
                        lane_code_next     = 8'd0;
                        lane_class_next    = CLS_FS;
                        byte_value_next    = tape_byte;
                        record_length_next = 16'd0;
                        last_next          = 1'b0;
                        status_next        = ST_OK;
                        if (header_count_reg == HDR_STATE_IDX) begin
                            header_count_next = 3'd0;
                            phase_next        = PH_LANE;
                            emit              = 1'b1;
                            item_type_next    = ITEM_HDR_STATE;
                        end else begin
                            header_count_next = header_count_reg + 3'd1;
                            if (header_count_reg == HDR_INPUT_IDX) begin
                                emit           = 1'b1;
                                item_type_next = ITEM_HDR_INPUT;
                            end
                        end
                    end
                endcase
            end
        end

        if (s_fire) begin
            m_valid_next = emit;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_HEADER;
            header_count_reg    <= 3'd0;
            current_lane_reg    <= 8'd0;
            length_high_reg     <= 8'd0;
            declared_length_reg <= 16'd0;
            remaining_reg       <= 16'd0;
            m_valid_reg         <= 1'b0;
        end else begin
            phase_reg           <= phase_next;
            header_count_reg    <= header_count_next;
            current_lane_reg    <= current_lane_next;
            length_high_reg     <= length_high_next;
            declared_length_reg <= declared_length_next;
            remaining_reg       <= remaining_next;
            m_valid_reg         <= m_valid_next;
        end

        // result fields need no reset
        if (s_fire && emit) begin
            item_type_reg     <= item_type_next;
            lane_code_reg     <= lane_code_next;
            lane_class_reg    <= lane_class_next;
            byte_value_reg    <= byte_value_next;
            record_length_reg <= record_length_next;
            last_reg          <= last_next;
            status_reg        <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = item_type_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {3'b000, status_reg, record_length_reg, byte_value_reg,
                       lane_class_reg, lane_code_reg};

    // payload phase always has bytes left to take
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> remaining_reg != 16'd0)
        else $error("payload phase with nothing remaining");

    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> remaining_reg <= declared_length_reg)
        else $error("remaining count above declared length");

    // header counter only moves inside the header
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_HEADER |-> header_count_reg == 3'd0)
        else $error("header count left over outside header");

    // end of tape re-arms the parser and always reports
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tuser |=> phase_reg == PH_HEADER && header_count_reg == 3'd0
                              && m_valid_reg && item_type_reg == ITEM_END)
        else $error("end of tape did not re-arm");

    // an end-status result never carries last
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && item_type_reg == ITEM_END |-> !last_reg)
        else $error("last set on end status");

endmodule
